@@ hw/rtl/request_slot_tracker_core_defines.svh @@
// Assertion macros for the request slot tracker.
`ifndef REQUEST_SLOT_TRACKER_CORE_DEFINES_SVH
`define REQUEST_SLOT_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTH
`define RSTRK_ASSERT(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) \
   prop) else $error("slot tracker check failed");
`define RSTRK_NEVER(lbl, cond) lbl: assert property (@(posedge clock) disable iff (reset) \
   !(cond)) else $error("slot tracker forbidden condition");
`else
`define RSTRK_ASSERT(lbl, prop)
`define RSTRK_NEVER(lbl, cond)
`endif
`endif

@@ hw/rtl/rstrk_pkg.sv @@
// Types, codes and sizes shared by the request slot tracker.
package rstrk_pkg;
   localparam int QUEUE_COUNT     = 2;
   localparam int SLOTS_PER_QUEUE = 8;
   localparam int TOTAL_SLOTS     = QUEUE_COUNT * SLOTS_PER_QUEUE;
   localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int POS_W  = $clog2(TOTAL_SLOTS + 1);
   localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int SPOS_W = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;

   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_FETCH   = 3'd1;
   localparam logic [2:0] OP_REPORT  = 3'd2;
   localparam logic [2:0] OP_FAULT   = 3'd3;
   localparam logic [2:0] OP_COLLECT = 3'd4;
   localparam logic [2:0] OP_REAP    = 3'd5;
   localparam logic [2:0] OP_COUNT   = 3'd6;

   localparam logic [2:0] SC_PENDING = 3'd0;
   localparam logic [2:0] SC_RUNNING = 3'd1;
   localparam logic [2:0] SC_DONE    = 3'd2;
   localparam logic [2:0] SC_FAILED  = 3'd3;
   localparam logic [2:0] SC_TERM    = 3'd4;

   localparam logic [1:0] WK_NONE   = 2'd0;
   localparam logic [1:0] WK_SERVER = 2'd1;
   localparam logic [1:0] WK_CALLER = 2'd2;
   localparam logic [1:0] WK_REAPER = 2'd3;

   localparam logic [1:0] RK_RUN  = 2'd0;
   localparam logic [1:0] RK_PEND = 2'd1;
   localparam logic [1:0] RK_FAIL = 2'd2;
   localparam logic [1:0] RK_NONE = 2'd3;

   localparam logic [1:0] KIND_LIST = 2'd1;
   localparam logic [4:0] COUNT_MAX = 5'd31;

   typedef struct packed {
      logic [2:0]  operation;
      logic [2:0]  queue_id;
      logic [2:0]  target_slot;
      logic [7:0]  caller_id;
      logic [1:0]  request_kind;
      logic        outcome;
      logic [15:0] result_value;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [2:0]  slot_index;
      logic [15:0] value;
      logic [4:0]  entry_count;
      logic [7:0]  entry_caller;
      logic [1:0]  entry_kind;
      logic [1:0]  wake_kind;
      logic [7:0]  wake_task;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  caller;
      logic [1:0]  kind;
      logic [15:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_UPDATE,
      S_RESULT
   } state_type;

   // Fetch priority: in progress first, then pending, then failed.
   function automatic logic [1:0] rank_of(input logic [2:0] code);
      logic [1:0] r;
      case (code)
         SC_RUNNING: r = RK_RUN;
         SC_PENDING: r = RK_PEND;
         SC_FAILED:  r = RK_FAIL;
         default:    r = RK_NONE;
      endcase
      return r;
   endfunction
endpackage

@@ hw/rtl/request_slot_tracker_core.sv @@
// Request slot tracker: slot table in one memory, walked by a scan sequencer.
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_data  (req_type)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (rsp_type)
//  csr     | in        | csr_valid/csr_ready  | csr_data  (reaper task id)
// Enqueue needs no scan; report and fault read one slot, fetch, collect
// and count SLOTS_PER_QUEUE, reap TOTAL_SLOTS: the scan reads one slot per
// cycle through the single read port of the slot memory.
// Reset clears the used bits and the recorded fetch slots; entry data is
// only read for used slots. A stalled result stays in its output register
// and the next request is taken meanwhile.
`include "request_slot_tracker_core_defines.svh"
module request_slot_tracker_core
   import rstrk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [7:0] csr_data
);
   state_type state_ff, state_in;
   req_type   req_ff;
   logic [7:0] reaper_ff;
   logic [TOTAL_SLOTS-1:0] used_ff, used_in;
   logic [SPOS_W-1:0] last_pos_ff [QUEUE_COUNT];
   logic [QUEUE_COUNT-1:0] last_valid_ff;

   entry_type mem [TOTAL_SLOTS];
   entry_type rd_data_ff;
   logic rd_en, mem_we;
   logic [ADDR_W-1:0] rd_addr, mem_waddr, rd_addr_ff;
   entry_type mem_wdata;

   logic [POS_W-1:0] iss_ff, iss_in, rd_pos_ff, scan_len_ff, scan_len_in;
   logic rd_valid_ff;
   logic [1:0] sel_rank_ff, sel_rank_in;
   logic [SPOS_W-1:0] sel_pos_ff, sel_pos_in;
   entry_type sel_entry_ff, sel_entry_in;
   logic reap_wake_ff, reap_wake_in;
   logic [4:0] cnt_ff, cnt_in;
   rsp_type res_ff, res_in;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic out_free, load_out, last_set;

   logic q_ok, tslot_ok, fault_ok, free_found, scan_ok, scan_done;
   logic [QIDX_W-1:0] q_idx;
   logic [ADDR_W-1:0] base, scan_start;
   logic [SPOS_W-1:0] free_pos, fault_pos, tslot;
   logic ev_used;
   logic [ADDR_W-1:0] pos_addr;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == S_RESULT) && out_free;

   // Request decode against flop state.
   always_comb begin
      q_ok  = {1'b0, req_ff.queue_id} < 4'(QUEUE_COUNT);
      q_idx = req_ff.queue_id[QIDX_W-1:0];
      base  = q_ok ? ADDR_W'(int'(req_ff.queue_id) * SLOTS_PER_QUEUE) : '0;
      tslot = req_ff.target_slot[SPOS_W-1:0];
      fault_pos = q_ok ? last_pos_ff[q_idx] : '0;
      tslot_ok = q_ok && ({1'b0, req_ff.target_slot} < 4'(SLOTS_PER_QUEUE)) &&
                 used_ff[ADDR_W'(int'(base) + int'(tslot))];
      fault_ok = q_ok && last_valid_ff[q_idx] &&
                 used_ff[ADDR_W'(int'(base) + int'(fault_pos))];
      free_found = 1'b0;
      free_pos   = '0;
      for (int i = SLOTS_PER_QUEUE - 1; i >= 0; i--) begin
         if (!used_ff[ADDR_W'(int'(base) + i)]) begin
            free_found = 1'b1;
            free_pos   = SPOS_W'(i);
         end
      end
      case (req_ff.operation)
         OP_REAP:   scan_start = '0;
         OP_REPORT: scan_start = ADDR_W'(int'(base) + int'(tslot));
         OP_FAULT:  scan_start = ADDR_W'(int'(base) + int'(fault_pos));
         default:   scan_start = base;
      endcase
      case (req_ff.operation)
         OP_FETCH, OP_COLLECT, OP_COUNT: scan_ok = q_ok;
         OP_REPORT: scan_ok = tslot_ok;
         OP_FAULT:  scan_ok = fault_ok;
         OP_REAP:   scan_ok = 1'b1;
         default:   scan_ok = 1'b0;
      endcase
      case (req_ff.operation)
         OP_REAP:             scan_len_in = POS_W'(TOTAL_SLOTS);
         OP_REPORT, OP_FAULT: scan_len_in = POS_W'(1);
         default:             scan_len_in = POS_W'(SLOTS_PER_QUEUE);
      endcase
      scan_done = rd_valid_ff && (rd_pos_ff == scan_len_ff - POS_W'(1));
      ev_used   = used_ff[rd_addr_ff];
      pos_addr  = ADDR_W'(int'(base) + int'(sel_pos_ff));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECODE;
         S_DECODE: state_in = (req_ff.operation != OP_ENQUEUE && scan_ok) ? S_SCAN : S_RESULT;
         S_SCAN:   if (scan_done) state_in = S_UPDATE;
         S_UPDATE: state_in = S_RESULT;
         S_RESULT: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      used_in      = used_ff;
      iss_in       = iss_ff;
      sel_rank_in  = sel_rank_ff;
      sel_pos_in   = sel_pos_ff;
      sel_entry_in = sel_entry_ff;
      reap_wake_in = reap_wake_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(int'(scan_start) + int'(iss_ff));
      mem_we       = 1'b0;
      mem_waddr    = pos_addr;
      mem_wdata    = sel_entry_ff;
      last_set     = 1'b0;
      case (state_ff)
         S_DECODE: begin
            res_in = '0;
            res_in.status = 1'b1;
            iss_in = '0;
            sel_rank_in = RK_NONE;
            reap_wake_in = 1'b0;
            cnt_in = '0;
            if (req_ff.operation == OP_ENQUEUE && q_ok && free_found) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(int'(base) + int'(free_pos));
               mem_wdata = '{status: SC_PENDING, caller: req_ff.caller_id,
                             kind: req_ff.request_kind, value: 16'd0};
               used_in[ADDR_W'(int'(base) + int'(free_pos))] = 1'b1;
               res_in.status     = 1'b0;
               res_in.slot_index = 3'(free_pos);
               res_in.wake_kind  = WK_SERVER;
               res_in.wake_task  = 8'(req_ff.queue_id);
            end
         end
         S_SCAN: begin
            if (iss_ff < scan_len_ff) begin
               rd_en  = 1'b1;
               iss_in = iss_ff + POS_W'(1);
            end
            if (rd_valid_ff) begin
               case (req_ff.operation)
                  OP_FETCH: begin
                     if (ev_used && rank_of(rd_data_ff.status) < sel_rank_ff) begin
                        sel_rank_in  = rank_of(rd_data_ff.status);
                        sel_pos_in   = rd_pos_ff[SPOS_W-1:0];
                        sel_entry_in = rd_data_ff;
                     end
                  end
                  OP_COLLECT: begin
                     if (sel_rank_ff == RK_NONE && ev_used &&
                         rd_data_ff.caller == req_ff.caller_id) begin
                        if (rd_data_ff.status == SC_DONE) begin
                           sel_rank_in  = RK_RUN;
                           sel_pos_in   = rd_pos_ff[SPOS_W-1:0];
                           sel_entry_in = rd_data_ff;
                        end else if (rd_data_ff.status == SC_TERM) begin
                           reap_wake_in = 1'b1;
                        end
                     end
                  end
                  OP_COUNT: begin
                     if (ev_used && (rd_data_ff.status == SC_PENDING ||
                                     rd_data_ff.status == SC_RUNNING) && cnt_ff != COUNT_MAX)
                        cnt_in = cnt_ff + 5'd1;
                  end
                  OP_REAP: begin
                     if (ev_used && rd_data_ff.status == SC_TERM) begin
                        used_in[rd_addr_ff] = 1'b0;
                        if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 5'd1;
                     end
                  end
                  default: begin
                     sel_entry_in = rd_data_ff;
                  end
               endcase
            end
         end
         S_UPDATE: begin
            res_in = '0;
            case (req_ff.operation)
               OP_FETCH: begin
                  if (sel_rank_ff == RK_NONE) begin
                     res_in.status = 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     mem_wdata.status = SC_RUNNING;
                     last_set = 1'b1;
                     res_in.slot_index   = 3'(sel_pos_ff);
                     res_in.entry_caller = sel_entry_ff.caller;
                     res_in.entry_kind   = sel_entry_ff.kind;
                  end
               end
               OP_REPORT: begin
                  mem_we    = 1'b1;
                  mem_waddr = scan_start;
                  mem_wdata = '{status: req_ff.outcome ? SC_FAILED : SC_DONE,
                                caller: rd_data_ff.caller, kind: rd_data_ff.kind,
                                value: req_ff.result_value};
                  res_in.slot_index = 3'(tslot);
               end
               OP_FAULT: begin
                  mem_we    = 1'b1;
                  mem_waddr = scan_start;
                  mem_wdata = rd_data_ff;
                  mem_wdata.status  = SC_TERM;
                  res_in.slot_index = 3'(fault_pos);
                  res_in.wake_kind  = WK_CALLER;
                  res_in.wake_task  = rd_data_ff.caller;
               end
               OP_COLLECT: begin
                  if (sel_rank_ff == RK_NONE) begin
                     res_in.status = 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     mem_wdata.status  = SC_TERM;
                     res_in.slot_index = 3'(sel_pos_ff);
                     res_in.value = (sel_entry_ff.kind <= KIND_LIST) ?
                                    sel_entry_ff.value : 16'd0;
                  end
                  if (reap_wake_ff) begin
                     res_in.wake_kind = WK_REAPER;
                     res_in.wake_task = reaper_ff;
                  end
               end
               default: begin
                  res_in.entry_count = cnt_ff;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         reaper_ff     <= 8'd0;
         used_ff       <= '0;
         last_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         rd_valid_ff <= rd_en;
         if (csr_valid) reaper_ff <= csr_data;
         if (last_set) last_valid_ff[q_idx] <= 1'b1;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == S_DECODE) scan_len_ff <= scan_len_in;
      if (last_set) last_pos_ff[q_idx] <= sel_pos_ff;
      if (load_out) rsp_data_ff <= res_ff;
      iss_ff       <= iss_in;
      rd_pos_ff    <= iss_ff;
      rd_addr_ff   <= rd_addr;
      sel_rank_ff  <= sel_rank_in;
      sel_pos_ff   <= sel_pos_in;
      sel_entry_ff <= sel_entry_in;
      reap_wake_ff <= reap_wake_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   `RSTRK_ASSERT(a_accept_decodes, (req_valid && !req_stall) |=> (state_ff == S_DECODE))
   `RSTRK_ASSERT(a_issue_bound, (state_ff == S_SCAN) |-> (iss_ff <= scan_len_ff))
   `RSTRK_NEVER(a_no_read_in_decode, (state_ff == S_DECODE) && rd_valid_ff)
   `RSTRK_ASSERT(a_result_loaded, load_out |=> rsp_valid_ff)
endmodule

@@ sim/request_slot_tracker_core_tb.sv @@
// Self-checking testbench for the request slot tracker core.
module request_slot_tracker_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rstrk_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = TOTAL_SLOTS + 12;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = '0;

   // Predicted copy of the slot table.
   logic       tbl_used [TOTAL_SLOTS];
   logic [2:0] tbl_status [TOTAL_SLOTS];
   logic [7:0] tbl_caller [TOTAL_SLOTS];
   logic [1:0] tbl_kind [TOTAL_SLOTS];
   logic [15:0] tbl_value [TOTAL_SLOTS];
   logic [2:0] fetched_slot [QUEUE_COUNT];
   logic       fetched_valid [QUEUE_COUNT];
   logic [7:0] reaper_id;

   rsp_type    expected_rsps[$];
   int         error_count = 0;
   int         requests_sent = 0;
   int         responses_seen = 0;
   int         idle_cycles = 0;
   bit         stall_enable = 1'b1;

   request_slot_tracker_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int find_status(int base, logic [2:0] code);
      for (int i = 0; i < SLOTS_PER_QUEUE; i++)
         if (tbl_used[base + i] && tbl_status[base + i] == code) return i;
      return -1;
   endfunction

   function automatic rsp_type predict_response(req_type rq);
      rsp_type r;
      int      base;
      int      s;
      int      n;
      int      k;
      bit      qok;
      r = '0;
      r.status = 1'b1;
      qok = rq.queue_id < QUEUE_COUNT;
      base = qok ? int'(rq.queue_id) * SLOTS_PER_QUEUE : 0;
      case (rq.operation)
         OP_ENQUEUE: if (qok) begin
            for (int i = 0; i < SLOTS_PER_QUEUE; i++) begin
               k = base + i;
               if (!tbl_used[k]) begin
                  tbl_used[k] = 1'b1;
                  tbl_status[k] = SC_PENDING;
                  tbl_caller[k] = rq.caller_id;
                  tbl_kind[k] = rq.request_kind;
                  tbl_value[k] = '0;
                  r.status = 1'b0;
                  r.slot_index = 3'(i);
                  r.wake_kind = WK_SERVER;
                  r.wake_task = 8'(rq.queue_id);
                  break;
               end
            end
         end
         OP_FETCH: if (qok) begin
            s = find_status(base, SC_RUNNING);
            if (s < 0) s = find_status(base, SC_PENDING);
            if (s < 0) s = find_status(base, SC_FAILED);
            if (s >= 0) begin
               tbl_status[base + s] = SC_RUNNING;
               fetched_slot[rq.queue_id] = 3'(s);
               fetched_valid[rq.queue_id] = 1'b1;
               r.status = 1'b0;
               r.slot_index = 3'(s);
               r.entry_caller = tbl_caller[base + s];
               r.entry_kind = tbl_kind[base + s];
            end
         end
         OP_REPORT: if (qok && rq.target_slot < SLOTS_PER_QUEUE
                        && tbl_used[base + rq.target_slot]) begin
            k = base + rq.target_slot;
            tbl_status[k] = rq.outcome ? SC_FAILED : SC_DONE;
            tbl_value[k] = rq.result_value;
            r.status = 1'b0;
            r.slot_index = rq.target_slot;
         end
         OP_FAULT: if (qok && fetched_valid[rq.queue_id]) begin
            k = base + fetched_slot[rq.queue_id];
            if (tbl_used[k]) begin
               tbl_status[k] = SC_TERM;
               r.status = 1'b0;
               r.slot_index = fetched_slot[rq.queue_id];
               r.wake_kind = WK_CALLER;
               r.wake_task = tbl_caller[k];
            end
         end
         OP_COLLECT: if (qok) begin
            for (int i = 0; i < SLOTS_PER_QUEUE; i++) begin
               k = base + i;
               if (tbl_used[k] && tbl_caller[k] == rq.caller_id) begin
                  if (tbl_status[k] == SC_DONE) begin
                     tbl_status[k] = SC_TERM;
                     r.status = 1'b0;
                     r.slot_index = 3'(i);
                     r.value = tbl_kind[k] <= KIND_LIST ? tbl_value[k] : 16'd0;
                     break;
                  end
                  if (tbl_status[k] == SC_TERM) begin
                     r.wake_kind = WK_REAPER;
                     r.wake_task = reaper_id;
                  end
               end
            end
         end
         OP_REAP: begin
            n = 0;
            for (int i = 0; i < TOTAL_SLOTS; i++)
               if (tbl_used[i] && tbl_status[i] == SC_TERM) begin
                  tbl_used[i] = 1'b0;
                  n++;
               end
            r.status = 1'b0;
            r.entry_count = n > 31 ? COUNT_MAX : 5'(n);
         end
         OP_COUNT: if (qok) begin
            n = 0;
            for (int i = 0; i < SLOTS_PER_QUEUE; i++)
               if (tbl_used[base + i] && (tbl_status[base + i] == SC_PENDING
                                          || tbl_status[base + i] == SC_RUNNING))
                  n++;
            r.status = 1'b0;
            r.entry_count = n > 31 ? COUNT_MAX : 5'(n);
         end
         default: ;
      endcase
      return r;
   endfunction

   // A zero gap keeps valid high, so requests follow back to back.
   task automatic send_request(req_type rq);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(predict_response(rq));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reaper_id(logic [7:0] id);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= id;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reaper_id = id;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_request(logic [2:0] op, logic [2:0] q);
      req_type rq;
      rq.operation = op;
      rq.queue_id = q;
      rq.target_slot = 3'($urandom_range(0, 7));
      rq.caller_id = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 3));
      rq.request_kind = 2'($urandom_range(0, 3));
      rq.outcome = 1'($urandom_range(0, 1));
      rq.result_value = 16'($urandom_range(0, 65535));
      return rq;
   endfunction

   task automatic test_directed();
      req_type rq;
      // Operations on an invalid queue and an unused operation code.
      for (int op = 0; op < 8; op++) begin
         rq = make_request(3'(op), 3'd7);
         send_request(rq);
      end
      rq = make_request(OP_FAULT, 3'd0);
      send_request(rq);
      // Fill queue 0 past full, with extreme field values.
      for (int i = 0; i <= SLOTS_PER_QUEUE; i++) begin
         rq = make_request(OP_ENQUEUE, 3'd0);
         rq.caller_id = i[0] ? 8'hFF : 8'h00;
         rq.request_kind = i[1:0];
         send_request(rq);
      end
      rq = make_request(OP_FETCH, 3'd0);
      send_request(rq);
      rq = make_request(OP_REPORT, 3'd0);
      rq.target_slot = 3'd1; rq.outcome = 1'b0; rq.result_value = 16'hFFFF;
      send_request(rq);
      rq.operation = OP_COLLECT; rq.caller_id = 8'hFF;
      send_request(rq);
      rq = make_request(OP_FAULT, 3'd0);
      send_request(rq);
      rq.operation = OP_COLLECT; rq.caller_id = 8'h00;
      send_request(rq);
      rq = make_request(OP_COUNT, 3'd0);
      send_request(rq);
      rq.operation = OP_REAP;
      send_request(rq);
      rq = make_request(OP_FETCH, 3'd1);
      send_request(rq);
   endtask

   task automatic test_random(int count);
      req_type rq;
      int      r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 22) rq = make_request(OP_ENQUEUE, 3'd0);
         else if (r < 38) rq = make_request(OP_FETCH, 3'd0);
         else if (r < 56) rq = make_request(OP_REPORT, 3'd0);
         else if (r < 64) rq = make_request(OP_FAULT, 3'd0);
         else if (r < 80) rq = make_request(OP_COLLECT, 3'd0);
         else if (r < 88) rq = make_request(OP_REAP, 3'd0);
         else if (r < 95) rq = make_request(OP_COUNT, 3'd0);
         else rq = make_request(3'($urandom_range(0, 7)), 3'd0);
         rq.queue_id = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(0, QUEUE_COUNT - 1));
         // Stretches of back-pressure-free traffic.
         if (i % 100 == 0) stall_enable = ~stall_enable;
         send_request(rq);
      end
      stall_enable = 1'b1;
   endtask

   // Result side: random stalls, checking in order.
   always @(negedge clock) begin
      if (reset || !stall_enable) rsp_stall <= 1'b0;
      else rsp_stall <= $urandom_range(0, 99) < 30
                        ? 1'b1 : ($urandom_range(0, 99) < 3 ? 1'b1 : 1'b0);
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data !== exp_rsp) begin
               $display("%0t: response mismatch expected %h actual %h",
                        $time, exp_rsp, rsp_data);
               $display("%0t:  status %0d/%0d slot %0d/%0d value %0h/%0h cnt %0d/%0d",
                        $time, exp_rsp.status, rsp_data.status, exp_rsp.slot_index,
                        rsp_data.slot_index, exp_rsp.value, rsp_data.value,
                        exp_rsp.entry_count, rsp_data.entry_count);
               $display("%0t:  caller %0h/%0h kind %0d/%0d wake %0d:%0h/%0d:%0h",
                        $time, exp_rsp.entry_caller, rsp_data.entry_caller,
                        exp_rsp.entry_kind, rsp_data.entry_kind, exp_rsp.wake_kind,
                        exp_rsp.wake_task, rsp_data.wake_kind, rsp_data.wake_task);
               error_count++;
            end
         end
      end
   end

   // Stalled responses from random back-pressure stretches are bounded well below this.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
         tbl_used[i] = 1'b0; tbl_status[i] = '0; tbl_caller[i] = '0;
         tbl_kind[i] = '0; tbl_value[i] = '0;
      end
      for (int q = 0; q < QUEUE_COUNT; q++) begin
         fetched_slot[q] = '0; fetched_valid[q] = 1'b0;
      end
      reaper_id = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      write_reaper_id(8'hFF);
      test_random(220);
      write_reaper_id(8'h00);
      test_random(200);
      write_reaper_id(8'($urandom_range(1, 254)));
      test_random(210);
      wait_idle();
      $display("Covered %0d requests and %0d responses across three reaper ids,",
               requests_sent, responses_seen);
      $display("including invalid queues, full queues, faults and reaps.");
      if (error_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
